// ===== sv/mcpr_pkg.sv =====
`default_nettype none

package mcpr_pkg;

  localparam int unsigned TargetWidth = 8;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned GainWidth   = 16;
  localparam int unsigned LoopWidth   = 8;
  localparam int unsigned MultWidth   = 10;
  localparam int unsigned AccWidth    = 32;

  localparam logic [TargetWidth-1:0] DutyFull     = 8'd255;
  localparam logic [MultWidth-1:0]   MultAtZero   = 10'd1000;
  localparam logic [MultWidth-1:0]   MultAtReset  = 10'd100;
  localparam logic [LoopWidth-1:0]   LoopAtReset  = 8'd10;
  localparam logic [GainWidth-1:0]   GainPAtReset = 16'd256;

  typedef enum logic [2:0] {
    REG_RAMP_MODE      = 3'd0,
    REG_BRAKE_LEVEL    = 3'd1,
    REG_ENCODER_ENABLE = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_STEP_TICKS     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic                   ramp_mode;
    logic                   brake_level;
    logic                   encoder_enable;
    logic [GainWidth-1:0]   gain_p;
    logic [GainWidth-1:0]   gain_i;
    logic [LoopWidth-1:0]   step_ticks;
    logic [MultWidth-1:0]   rate_mult;
  } cfg_t;

  typedef struct packed {
    logic [TargetWidth-1:0]        target_power;
    logic                          direction;
    logic signed [CountWidth-1:0]  encoder_count;
  } item_t;

  typedef struct packed {
    logic [LoopWidth-1:0]          tick_counter;
    logic [TargetWidth-1:0]        duty;
    logic signed [AccWidth-1:0]    integral_acc;
    logic                          held_direction;
    logic                          leg_a;
    logic                          leg_b;
    logic [TargetWidth-1:0]        pwm_level;
    logic signed [CountWidth-1:0]  last_position;
    logic signed [CountWidth-1:0]  last_rate;
  } state_t;

  // Counts-per-second multiplier, the integer quotient of 1000 by the loop time (1000 for a loop time of 0).
  function automatic logic [MultWidth-1:0] rate_mult(input logic [LoopWidth-1:0] lt);
    logic [MultWidth-1:0] m;
    begin
      m = 10'd3;
      if      (lt >= 8'd251) m = 10'd3;
      else if (lt >= 8'd201) m = 10'd4;
      else if (lt >= 8'd167) m = 10'd5;
      else if (lt >= 8'd143) m = 10'd6;
      else if (lt >= 8'd126) m = 10'd7;
      else if (lt >= 8'd112) m = 10'd8;
      else if (lt >= 8'd101) m = 10'd9;
      else if (lt >= 8'd91)  m = 10'd10;
      else if (lt >= 8'd84)  m = 10'd11;
      else if (lt >= 8'd77)  m = 10'd12;
      else if (lt >= 8'd72)  m = 10'd13;
      else if (lt >= 8'd67)  m = 10'd14;
      else if (lt >= 8'd63)  m = 10'd15;
      else if (lt >= 8'd59)  m = 10'd16;
      else if (lt >= 8'd56)  m = 10'd17;
      else if (lt >= 8'd53)  m = 10'd18;
      else if (lt >= 8'd51)  m = 10'd19;
      else if (lt >= 8'd48)  m = 10'd20;
      else if (lt >= 8'd46)  m = 10'd21;
      else if (lt >= 8'd44)  m = 10'd22;
      else if (lt >= 8'd42)  m = 10'd23;
      else if (lt >= 8'd41)  m = 10'd24;
      else begin
        case (lt[5:0])
          6'd0:  m = MultAtZero;
          6'd1:  m = 10'd1000;
          6'd2:  m = 10'd500;
          6'd3:  m = 10'd333;
          6'd4:  m = 10'd250;
          6'd5:  m = 10'd200;
          6'd6:  m = 10'd166;
          6'd7:  m = 10'd142;
          6'd8:  m = 10'd125;
          6'd9:  m = 10'd111;
          6'd10: m = 10'd100;
          6'd11: m = 10'd90;
          6'd12: m = 10'd83;
          6'd13: m = 10'd76;
          6'd14: m = 10'd71;
          6'd15: m = 10'd66;
          6'd16: m = 10'd62;
          6'd17: m = 10'd58;
          6'd18: m = 10'd55;
          6'd19: m = 10'd52;
          6'd20: m = 10'd50;
          6'd21: m = 10'd47;
          6'd22: m = 10'd45;
          6'd23: m = 10'd43;
          6'd24: m = 10'd41;
          6'd25: m = 10'd40;
          6'd26: m = 10'd38;
          6'd27: m = 10'd37;
          6'd28: m = 10'd35;
          6'd29: m = 10'd34;
          6'd30: m = 10'd33;
          6'd31: m = 10'd32;
          6'd32: m = 10'd31;
          6'd33: m = 10'd30;
          6'd34: m = 10'd29;
          6'd35: m = 10'd28;
          6'd36: m = 10'd27;
          6'd37: m = 10'd27;
          6'd38: m = 10'd26;
          6'd39: m = 10'd25;
          6'd40: m = 10'd25;
          default: m = 10'd24;
        endcase
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/mcpr_step.sv =====
`default_nettype none

module mcpr_step (
  input  wire mcpr_pkg::cfg_t   cfg,
  input  wire mcpr_pkg::item_t  item,
  input  wire mcpr_pkg::state_t state,
  output logic                  step_done,
  output mcpr_pkg::state_t      state_next
);

  logic [7:0]         tick_inc;
  logic signed [8:0]  err;
  logic signed [25:0] p_term;
  logic signed [25:0] i_term;
  logic signed [32:0] acc_wide;
  logic signed [31:0] acc_sat;
  logic signed [34:0] sum;
  logic [7:0]         ramp_duty;
  logic               ramp_clear;
  logic signed [32:0] delta;
  logic signed [43:0] rate_wide;
  logic signed [31:0] rate_sat;
  logic               brake;

  always_comb begin
    tick_inc = state.tick_counter + 8'd1;
    step_done = (tick_inc >= cfg.step_ticks);

    err    = $signed({1'b0, item.target_power}) - $signed({1'b0, state.duty});
    p_term = err * $signed({1'b0, cfg.gain_p});
    i_term = err * $signed({1'b0, cfg.gain_i});

    acc_wide = 33'(state.integral_acc) + 33'(i_term);
    if (acc_wide[32] != acc_wide[31]) begin
      acc_sat = acc_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      acc_sat = acc_wide[31:0];
    end

    sum = $signed({19'b0, state.duty, 8'h00}) + 35'(p_term) + 35'(acc_sat);
    ramp_clear = 1'b0;
    if (sum > 35'sd65280) begin
      ramp_duty  = mcpr_pkg::DutyFull;
      ramp_clear = 1'b1;
    end else if (sum[34]) begin
      ramp_duty  = 8'd0;
      ramp_clear = 1'b1;
    end else begin
      ramp_duty = sum[15:8];
    end

    delta     = 33'(item.encoder_count) - 33'(state.last_position);
    rate_wide = 44'(delta) * $signed({34'b0, cfg.rate_mult});
    if (rate_wide > 44'sh0_7fff_ffff) begin
      rate_sat = 32'sh7fff_ffff;
    end else if (rate_wide < -44'sh0_8000_0000) begin
      rate_sat = 32'sh8000_0000;
    end else begin
      rate_sat = rate_wide[31:0];
    end

    state_next = state;
    brake = 1'b0;
    state_next.tick_counter = tick_inc;

    if (step_done) begin
      state_next.tick_counter = 8'd0;

      if (cfg.encoder_enable) begin
        state_next.last_rate     = rate_sat;
        state_next.last_position = item.encoder_count;
      end

      if (cfg.ramp_mode) begin
        if (state.duty != item.target_power) begin
          state_next.integral_acc = ramp_clear ? 32'sd0 : acc_sat;
          state_next.duty         = ramp_duty;
          state_next.pwm_level    = ramp_duty;
        end
        if (item.direction != state.held_direction) begin
          state_next.held_direction = item.direction;
          state_next.leg_a          = item.direction;
          state_next.leg_b          = ~item.direction;
        end
        brake = (state_next.duty == 8'd0);
      end else if (item.target_power != 8'd0) begin
        // After a direction update the legs follow the held direction either way.
        if (item.direction != state.held_direction || 
            (state.duty != item.target_power && state.duty == 8'd0)) begin
          state_next.held_direction = item.direction;
          state_next.leg_a          = item.direction;
          state_next.leg_b          = ~item.direction;
        end
        state_next.duty      = item.target_power;
        if (state.duty != item.target_power) begin
          state_next.pwm_level = item.target_power;
        end
      end else begin
        brake = 1'b1;
      end

      if (brake) begin
        state_next.duty      = 8'd0;
        state_next.leg_a     = cfg.brake_level;
        state_next.leg_b     = cfg.brake_level;
        state_next.pwm_level = cfg.brake_level ? mcpr_pkg::DutyFull : 8'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/motor_channel_pi_ramp.sv =====
// Motor channel controller: PI duty ramp, H-bridge drive and encoder rate.
// Each transfer on the s_ channel is one tick carrying the target duty,
// the direction and the encoder count. Every tick gives exactly one transfer
// on the m_ channel with the PWM level, both bridge legs, the latched encoder
// position and rate, and in m_tuser a flag that is set when a control step ran.
// Registers are written through the cfg_ channel, which is always ready; they
// should be written only while no tick is in flight.
// A tick is captured in an input register, its control step is evaluated in
// combinational logic (two narrow multipliers for the PI terms and one for the
// rate) and the result lands in the output register, from which the output
// transfer is made; one tick is taken every cycle while the receiver does not
// stall. When the receiver stalls, the result is held in the output register
// while one more tick can wait in the input register; s_tready then drops.
// Reset (synchronous) empties both registers, zeroes the duty, integral,
// position and rate, drives leg A low and leg B high, and loads the register
// defaults: direct mode, brake level low, encoder off, P gain 1.0, I gain 0
// and a loop time of 10 ticks.
`default_nettype none

module motor_channel_pi_ramp (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // target_power[7:0], direction[8], encoder_count[40:9]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [79:0] m_tdata,   // pwm_duty[7:0], bridge_a[8], bridge_b[9],
                                 // encoder_position[41:10], encoder_rate[73:42]
  output logic [0:0]  m_tuser,   // step_done[0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  mcpr_pkg::cfg_t   cfg;
  mcpr_pkg::state_t state;
  mcpr_pkg::state_t state_next;
  mcpr_pkg::item_t  item;
  logic             item_valid;
  logic             advance;
  logic             step_done;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && (!m_tvalid || m_tready);
  assign s_tready  = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_mode      <= 1'b0;
      cfg.brake_level    <= 1'b0;
      cfg.encoder_enable <= 1'b0;
      cfg.gain_p         <= mcpr_pkg::GainPAtReset;
      cfg.gain_i         <= '0;
      cfg.step_ticks     <= mcpr_pkg::LoopAtReset;
      cfg.rate_mult      <= mcpr_pkg::MultAtReset;
    end else if (cfg_valid) begin
      case (mcpr_pkg::reg_index_t'(cfg_index))
        mcpr_pkg::REG_RAMP_MODE:      cfg.ramp_mode      <= cfg_data[0];
        mcpr_pkg::REG_BRAKE_LEVEL:    cfg.brake_level    <= cfg_data[0];
        mcpr_pkg::REG_ENCODER_ENABLE: cfg.encoder_enable <= cfg_data[0];
        mcpr_pkg::REG_GAIN_P:         cfg.gain_p         <= cfg_data;
        mcpr_pkg::REG_GAIN_I:         cfg.gain_i         <= cfg_data;
        mcpr_pkg::REG_STEP_TICKS: begin
          cfg.step_ticks <= cfg_data[7:0];
          cfg.rate_mult  <= mcpr_pkg::rate_mult(cfg_data[7:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.target_power  <= s_tdata[7:0];
      item.direction     <= s_tdata[8];
      item.encoder_count <= s_tdata[40:9];
    end
  end

  mcpr_step u_step (
    .cfg        (cfg),
    .item       (item),
    .state      (state),
    .step_done  (step_done),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.tick_counter   <= '0;
      state.duty           <= '0;
      state.integral_acc   <= '0;
      state.held_direction <= 1'b0;
      state.leg_a          <= 1'b0;
      state.leg_b          <= 1'b1;
      state.pwm_level      <= '0;
      state.last_position  <= '0;
      state.last_rate      <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= step_done;
      m_tdata <= {6'b0, state_next.last_rate, state_next.last_position,
                  state_next.leg_b, state_next.leg_a, state_next.pwm_level};
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcpr_checker.sv =====
`default_nettype none

module mcpr_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [79:0] m_tdata
);

  // Both registers are empty right after reset.
  assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low after reset");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // The input side only stalls while a result waits on a stalled receiver.
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind motor_channel_pi_ramp mcpr_checker u_mcpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
